/* rtl/core/lsup_pkg.sv */
// ----------------------------------------------------------------------------
// lsup_pkg: shared types and constants of the link supervisor
// Command and result words, configuration snapshot, message and event codes.
// ----------------------------------------------------------------------------
package lsup_pkg;

  localparam int IdWidth = 8;
  localparam int VerWidth = 7;
  localparam int TimeoutWidth = 20;
  localparam int TimeWidth = 32;
  localparam int CfgIndexWidth = 8;
  localparam int CfgDataWidth = 20;

  localparam logic [15:0] VersionMax = 16'd100;
  localparam logic [TimeoutWidth:0] LostWindowMs = 21'd5000;
  localparam logic [TimeoutWidth-1:0] TimeoutReset = 20'd3000;

  // Register indexes of the configuration port
  localparam logic [CfgIndexWidth-1:0] REG_OWN_ID = 8'd0;
  localparam logic [CfgIndexWidth-1:0] REG_CONTROLLED = 8'd1;
  localparam logic [CfgIndexWidth-1:0] REG_IF_UP = 8'd2;
  localparam logic [CfgIndexWidth-1:0] REG_TIMEOUT = 8'd3;

  // Operation and message type codes of the input word
  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] MSG_CONTROL = 3'd0;
  localparam logic [2:0] MSG_SETUP = 3'd1;
  localparam logic [2:0] MSG_CONFIRM = 3'd2;
  localparam logic [2:0] MSG_TASK = 3'd3;
  localparam logic [2:0] MSG_END_WORK = 3'd4;
  localparam logic [2:0] MSG_STOP_TASK = 3'd5;

  // Event codes of the result word
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_RESTART = 3'd1;
  localparam logic [2:0] EV_OTHER_TASK = 3'd2;
  localparam logic [2:0] EV_END_WORK = 3'd3;
  localparam logic [2:0] EV_LINK_LOST = 3'd4;
  localparam logic [2:0] EV_STOPPED = 3'd5;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_CONTROL = 3'd1,
    CMD_SETUP   = 3'd2,
    CMD_CONFIRM = 3'd3,
    CMD_TASK    = 3'd4,
    CMD_END     = 3'd5,
    CMD_STOP    = 3'd6,
    CMD_TICK    = 3'd7
  } cmd_kind_t;

  typedef struct packed {
    logic [IdWidth-1:0]      own_id;
    logic                    controlled;
    logic                    if_up;
    logic [TimeoutWidth-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [IdWidth-1:0]   sender;
    logic [VerWidth-1:0]  version;
    logic [TimeWidth-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0]          event_code;
    logic                send_control;
    logic                send_confirm;
    logic [IdWidth-1:0]  destination_id;
    logic                link_is_up;
    logic [IdWidth-1:0]  task_source;
    logic                task_held;
    logic [VerWidth-1:0] peer_version;
  } res_t;

endpackage

/* rtl/core/lsup_front.sv */
// ----------------------------------------------------------------------------
// lsup_front: input classifier and command queue
// Decodes each input word into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module lsup_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsup_pkg::cfg_t                cfg,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_operation,
  input  logic [2:0]                    in_msg_type,
  input  logic [lsup_pkg::IdWidth-1:0]  in_sender_id,
  input  logic [15:0]                   in_version_in,
  input  logic [lsup_pkg::TimeWidth-1:0] in_now_ms,
  output logic                          cmd_valid,
  input  logic                          cmd_pop,
  output lsup_pkg::cmd_t                cmd
);
  import lsup_pkg::*;

  cmd_t       dec;
  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok, pop_ok;

  always_comb begin
    dec.sender = in_sender_id;
    dec.now = in_now_ms;
    dec.version = (in_version_in >= 16'd1 && in_version_in <= VersionMax) ?
                  in_version_in[VerWidth-1:0] : '0;
    dec.kind = CMD_NONE;
    if (in_operation == OP_TICK) begin
      dec.kind = CMD_TICK;
    end else if (cfg.controlled) begin
      case (in_msg_type)
        MSG_CONTROL:   dec.kind = (in_sender_id == cfg.own_id) ? CMD_NONE : CMD_CONTROL;
        MSG_SETUP:     dec.kind = CMD_SETUP;
        MSG_CONFIRM:   dec.kind = CMD_CONFIRM;
        MSG_TASK:      dec.kind = CMD_TASK;
        MSG_END_WORK:  dec.kind = CMD_END;
        MSG_STOP_TASK: dec.kind = CMD_STOP;
        default:       dec.kind = CMD_NONE;
      endcase
    end
  end

  assign in_full = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign push_ok = in_push && !in_full;
  assign pop_ok = cmd_pop && cmd_valid;
  assign cmd = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

/* rtl/core/lsup_back.sv */
// ----------------------------------------------------------------------------
// lsup_back: link state engine and result queue; while that queue has room,
// executes one command a cycle on the link state and queues the result word.
// ----------------------------------------------------------------------------
module lsup_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lsup_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  lsup_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output lsup_pkg::res_t res
);
  import lsup_pkg::*;

  logic                    link_up_r, link_up_nxt;
  logic [IdWidth-1:0]      peer_id_r, peer_id_nxt;
  logic [IdWidth-1:0]      task_src_r, task_src_nxt;
  logic                    task_present_r, task_present_nxt;
  logic                    conf_pend_r, conf_pend_nxt;
  logic [TimeWidth-1:0]    last_time_r, last_time_nxt;
  logic                    last_valid_r, last_valid_nxt;
  logic [VerWidth-1:0]     peer_ver_r, peer_ver_nxt;

  logic [TimeWidth-1:0]    delta;
  logic [TimeoutWidth:0]   limit_hi;
  logic                    overdue;
  res_t                    r_new;

  res_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       space, pop_ok;

  assign out_empty = (cnt_r == 2'd0);
  assign pop_ok = out_pop && !out_empty;
  assign space = (cnt_r != 2'd2) || pop_ok;
  assign cmd_pop = cmd_valid && space;
  assign res = q_r[rd_ptr_r];

  // Loss window: timeout < (now - last) < timeout + 5 s
  assign delta = cmd.now - last_time_r;
  assign limit_hi = {1'b0, cfg.timeout} + LostWindowMs;
  assign overdue = (delta > {{(TimeWidth-TimeoutWidth){1'b0}}, cfg.timeout}) &&
                   (delta < {{(TimeWidth-TimeoutWidth-1){1'b0}}, limit_hi});

  always_comb begin
    link_up_nxt = link_up_r;
    peer_id_nxt = peer_id_r;
    task_src_nxt = task_src_r;
    task_present_nxt = task_present_r;
    conf_pend_nxt = conf_pend_r;
    last_time_nxt = last_time_r;
    last_valid_nxt = last_valid_r;
    peer_ver_nxt = peer_ver_r;
    r_new = '0;
    r_new.event_code = EV_NONE;
    case (cmd.kind)
      CMD_CONTROL: begin
        if (!link_up_r) begin
          peer_id_nxt = cmd.sender;
          link_up_nxt = 1'b1;
        end
        last_time_nxt = cmd.now;
        last_valid_nxt = 1'b1;
      end
      CMD_SETUP: begin
        if (link_up_r) begin
          r_new.event_code = EV_RESTART;
        end
        peer_id_nxt = cmd.sender;
        peer_ver_nxt = cmd.version;
        link_up_nxt = 1'b1;
        conf_pend_nxt = 1'b1;
        last_valid_nxt = 1'b0;
      end
      CMD_CONFIRM: begin
        peer_id_nxt = cmd.sender;
        peer_ver_nxt = cmd.version;
        link_up_nxt = 1'b1;
        last_valid_nxt = 1'b0;
      end
      CMD_TASK: begin
        task_src_nxt = cmd.sender;
        if (task_present_r) begin
          r_new.event_code = EV_OTHER_TASK;
        end
        task_present_nxt = 1'b1;
      end
      CMD_END: begin
        r_new.event_code = EV_END_WORK;
        peer_id_nxt = '0;
        task_src_nxt = '0;
        last_valid_nxt = 1'b0;
      end
      CMD_STOP: begin
        task_src_nxt = cmd.sender;
        if (task_present_r) begin
          r_new.event_code = EV_STOPPED;
        end
      end
      CMD_TICK: begin
        if (cfg.if_up) begin
          if (!link_up_r) begin
            peer_id_nxt = cfg.own_id;
          end
          r_new.send_control = 1'b1;
        end
        if (cfg.controlled) begin
          if (conf_pend_r) begin
            r_new.send_confirm = 1'b1;
            conf_pend_nxt = 1'b0;
          end
          if (cfg.timeout != '0 && link_up_r && last_valid_r && overdue) begin
            r_new.event_code = EV_LINK_LOST;
            peer_id_nxt = '0;
            task_src_nxt = '0;
            last_valid_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    r_new.destination_id = peer_id_nxt;
    r_new.link_is_up = link_up_nxt;
    r_new.task_source = task_src_nxt;
    r_new.task_held = task_present_nxt;
    r_new.peer_version = peer_ver_nxt;
  end

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, cmd_pop} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_up_r <= 1'b0;
      peer_id_r <= '0;
      task_src_r <= '0;
      task_present_r <= 1'b0;
      conf_pend_r <= 1'b0;
      last_time_r <= '0;
      last_valid_r <= 1'b0;
      peer_ver_r <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (cmd_pop) begin
        link_up_r <= link_up_nxt;
        peer_id_r <= peer_id_nxt;
        task_src_r <= task_src_nxt;
        task_present_r <= task_present_nxt;
        conf_pend_r <= conf_pend_nxt;
        last_time_r <= last_time_nxt;
        last_valid_r <= last_valid_nxt;
        peer_ver_r <= peer_ver_nxt;
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      q_r[wr_ptr_r] <= r_new;
    end
  end

endmodule

/* rtl/core/link_supervisor.sv */
// ----------------------------------------------------------------------------
// link_supervisor: station side supervisor of the link to a central computer
// Tracks link state from received messages and periodic ticks.
// ----------------------------------------------------------------------------
// Input side is a queue: drive the word onto in_* and raise in_push; the word
// is taken on an edge where in_full is low. Each word is a received message
// or a tick and gives exactly one result word.
// Result side is a queue: while out_empty is low the oldest result is on the
// out_* ports; raise out_pop to take it.
// A word taken at an edge is decoded into the two-entry command queue,
// then executed by the state engine, whose result word is written into the
// result queue that drives out_*. Throughput is one word per cycle while the
// result queue has room.
// A stalled receiver fills the two-entry result queue, then the command
// queue, after which in_full rises; nothing is dropped.
// Configuration: cfg_valid with cfg_index and cfg_data, always ready; write
// only while idle. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) clears both queues and the link state and
// loads the register defaults: controlled mode on, timeout 3000 ms.
// ----------------------------------------------------------------------------
module link_supervisor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lsup_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [lsup_pkg::CfgDataWidth-1:0]   cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_operation,
  input  logic [2:0]                          in_msg_type,
  input  logic [lsup_pkg::IdWidth-1:0]        in_sender_id,
  input  logic [15:0]                         in_version_in,
  input  logic [lsup_pkg::TimeWidth-1:0]      in_now_ms,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [2:0]                          out_event_code,
  output logic                                out_send_control,
  output logic                                out_send_confirm,
  output logic [lsup_pkg::IdWidth-1:0]        out_destination_id,
  output logic                                out_link_is_up,
  output logic [lsup_pkg::IdWidth-1:0]        out_task_source,
  output logic                                out_task_held,
  output logic [lsup_pkg::VerWidth-1:0]       out_peer_version_out
);
  import lsup_pkg::*;

  cfg_t cfg_r;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id <= '0;
      cfg_r.controlled <= 1'b1;
      cfg_r.if_up <= 1'b0;
      cfg_r.timeout <= TimeoutReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_ID:     cfg_r.own_id <= cfg_data[IdWidth-1:0];
        REG_CONTROLLED: cfg_r.controlled <= cfg_data[0];
        REG_IF_UP:      cfg_r.if_up <= cfg_data[0];
        REG_TIMEOUT:    cfg_r.timeout <= cfg_data[TimeoutWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  lsup_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_operation  (in_operation),
    .in_msg_type   (in_msg_type),
    .in_sender_id  (in_sender_id),
    .in_version_in (in_version_in),
    .in_now_ms     (in_now_ms),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .cmd           (cmd)
  );

  lsup_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res)
  );

  assign out_event_code = res.event_code;
  assign out_send_control = res.send_control;
  assign out_send_confirm = res.send_confirm;
  assign out_destination_id = res.destination_id;
  assign out_link_is_up = res.link_is_up;
  assign out_task_source = res.task_source;
  assign out_task_held = res.task_held;
  assign out_peer_version_out = res.peer_version;

`ifndef SYNTHESIS
  a_ctrl_needs_if: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_send_control) |-> cfg_r.if_up)
    else $error("control send reported with interface down");

  a_conf_needs_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_send_confirm) |-> cfg_r.controlled)
    else $error("confirm send reported outside controlled mode");

  a_lost_teardown: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_code == EV_LINK_LOST) |->
      (out_destination_id == '0 && out_task_source == '0 && out_link_is_up))
    else $error("link loss without teardown");

  a_restart_up: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_code == EV_RESTART) |-> out_link_is_up)
    else $error("central restart reported with link down");
`endif

endmodule
